// ===== rtl/skt_pkg.sv =====
// Shared types, sizes and codes for the sorted key table.
// Used by every module of the block; it depends on nothing else.
`timescale 1ns / 1ps

package skt_pkg;

   localparam int CAPACITY       = 256;
   localparam int KEY_BITS       = 32;
   localparam int OPCODE_BITS    = 2;
   localparam int REQ_KEY_BITS   = 32;
   localparam int POS_BITS       = 8;
   localparam int COUNT_OUT_BITS = 9;

   localparam int CNT_BITS  = $clog2(CAPACITY + 1);
   localparam int IDX_BITS  = $clog2(CAPACITY);

   // The position encoder works on groups of sixteen cells.
   localparam int GROUP     = 16;
   localparam int LOC_BITS  = 4;
   localparam int NGROUPS   = (CAPACITY + GROUP - 1) / GROUP;
   localparam int GRP_BITS  = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
   localparam int TREE_BITS = GRP_BITS + LOC_BITS;
   localparam int PAD       = NGROUPS * GROUP;

   localparam logic [OPCODE_BITS-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_INSERT = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_DELETE = 2'd2;

   typedef logic [KEY_BITS-1:0] key_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_REDUCE,
      ST_SELECT,
      ST_APPLY
   } skt_state_type;

   // Commands broadcast to every cell of the chain.
   typedef struct packed {
      logic compare;
      logic insert;
      logic remove;
   } skt_ctrl_type;

   // Search outcome delivered by the position encoder.
   typedef struct packed {
      logic [IDX_BITS-1:0] index;
      logic                hit;
   } skt_sel_type;

endpackage

// ===== rtl/skt_cell.sv =====
// One cell of the sorted key chain: holds a key and its comparison flags.
// Depends on skt_pkg.
`timescale 1ns / 1ps

module skt_cell (
   input  logic                  clock,
   input  skt_pkg::skt_ctrl_type ctrl,
   input  skt_pkg::key_type      probe_key,
   input  logic                  occupied,
   input  logic                  left_lt,
   input  skt_pkg::key_type      left_key,
   input  skt_pkg::key_type      right_key,
   output skt_pkg::key_type      key_out,
   output logic                  lt_out,
   output logic                  eq_out
);

   skt_pkg::key_type key_ff, key_in;
   logic             lt_ff, lt_in;
   logic             eq_ff, eq_in;

   always_comb begin
      key_in = key_ff;
      lt_in  = lt_ff;
      eq_in  = eq_ff;
      if (ctrl.compare) begin
         lt_in = occupied && (key_ff < probe_key);
         eq_in = occupied && (key_ff == probe_key);
      end
      // Cells at or above the insertion point move up; the boundary cell takes the new key.
      if (ctrl.insert && !lt_ff) begin
         key_in = left_lt ? probe_key : left_key;
      end
      // Cells from the removed key upwards take their upper neighbour's key.
      if (ctrl.remove && !lt_ff) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      lt_ff  <= lt_in;
      eq_ff  <= eq_in;
   end

   assign key_out = key_ff;
   assign lt_out  = lt_ff;
   assign eq_out  = eq_ff;

endmodule

// ===== rtl/skt_encoder.sv =====
// Two-stage registered encoder: finds the insertion boundary and any match in the chain.
// Depends on skt_pkg.
`timescale 1ns / 1ps

module skt_encoder (
   input  logic                       clock,
   input  logic [skt_pkg::PAD-1:0]    bnd,
   input  logic [skt_pkg::PAD-1:0]    eq,
   output skt_pkg::skt_sel_type       sel
);

   logic [skt_pkg::NGROUPS-1:0]  g_any_ff, g_any_in;
   logic [skt_pkg::NGROUPS-1:0]  g_eq_ff, g_eq_in;
   logic [skt_pkg::LOC_BITS-1:0] g_loc_ff [skt_pkg::NGROUPS];
   logic [skt_pkg::LOC_BITS-1:0] g_loc_in [skt_pkg::NGROUPS];
   skt_pkg::skt_sel_type         sel_ff, sel_in;

   // First stage: encode within each group of cells.
   always_comb begin
      for (int g = 0; g < skt_pkg::NGROUPS; g++) begin
         g_any_in[g] = 1'b0;
         g_eq_in[g]  = 1'b0;
         g_loc_in[g] = '0;
         for (int j = 0; j < skt_pkg::GROUP; j++) begin
            g_any_in[g] = g_any_in[g] | bnd[g * skt_pkg::GROUP + j];
            g_eq_in[g]  = g_eq_in[g] | eq[g * skt_pkg::GROUP + j];
            if (bnd[g * skt_pkg::GROUP + j]) begin
               g_loc_in[g] = g_loc_in[g] | skt_pkg::LOC_BITS'(j);
            end
         end
      end
   end

   // Second stage: combine the groups; at most one boundary bit is set across the chain.
   always_comb begin
      logic [skt_pkg::GRP_BITS-1:0]  grp;
      logic [skt_pkg::LOC_BITS-1:0]  loc;
      logic [skt_pkg::TREE_BITS-1:0] tree;
      grp = '0;
      loc = '0;
      sel_in.hit   = |g_eq_ff;
      for (int g = 0; g < skt_pkg::NGROUPS; g++) begin
         if (g_any_ff[g]) begin
            grp = grp | skt_pkg::GRP_BITS'(g);
            loc = loc | g_loc_ff[g];
         end
      end
      tree = {grp, loc};
      sel_in.index = tree[skt_pkg::IDX_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      g_any_ff <= g_any_in;
      g_eq_ff  <= g_eq_in;
      g_loc_ff <= g_loc_in;
      sel_ff   <= sel_in;
   end

   assign sel = sel_ff;

endmodule

// ===== rtl/sorted_key_table_unit.sv =====
// Sorted key table: a chain of key cells kept in ascending order, with lookup, insert, delete.
// Each transaction is registered, compared in every cell, passed through two encoder stages and
// applied; rsp_valid rises with the shift, which waits while a stalled response is held.
// One transaction at a time: a new request is taken only in the idle state.
// Reset (synchronous, active high) empties the table and drops any pending response at once.
// Depends on skt_pkg, skt_cell and skt_encoder.
`timescale 1ns / 1ps

module sorted_key_table_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [skt_pkg::OPCODE_BITS-1:0]    req_opcode,
   input  logic [skt_pkg::REQ_KEY_BITS-1:0]   req_key,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_found,
   output logic [skt_pkg::POS_BITS-1:0]       rsp_position,
   output logic                               rsp_full_res,
   output logic [skt_pkg::COUNT_OUT_BITS-1:0] rsp_entry_count
);

   // Control state.
   skt_pkg::skt_state_type state_ff, state_in;
   logic [skt_pkg::CNT_BITS-1:0] count_ff, count_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // The transaction being worked on.
   logic [skt_pkg::OPCODE_BITS-1:0] op_ff, op_in;
   skt_pkg::key_type                probe_ff, probe_in;

   // Response payload registers.
   logic                               found_ff, found_in;
   logic [skt_pkg::POS_BITS-1:0]       pos_ff, pos_in;
   logic                               full_ff, full_in;
   logic [skt_pkg::COUNT_OUT_BITS-1:0] cnt_out_ff, cnt_out_in;

   skt_pkg::skt_ctrl_type ctrl;
   skt_pkg::skt_sel_type  sel;

   // Chain wiring.
   skt_pkg::key_type          cell_key [skt_pkg::CAPACITY];
   logic [skt_pkg::CAPACITY-1:0] cell_lt;
   logic [skt_pkg::CAPACITY-1:0] cell_eq;
   logic [skt_pkg::CAPACITY-1:0] occ;
   logic [skt_pkg::PAD-1:0]      bnd_vec;
   logic [skt_pkg::PAD-1:0]      eq_vec;

   // Each cell compares its own key with the probe; the cells below the
   // insertion point keep their key, the rest shift by one place.
   for (genvar i = 0; i < skt_pkg::CAPACITY; i++) begin : g_cell
      skt_pkg::key_type left_key;
      skt_pkg::key_type right_key;
      logic             left_lt;

      assign occ[i] = skt_pkg::CNT_BITS'(i) < count_ff;

      if (i == 0) begin : g_first
         assign left_lt  = 1'b1;
         assign left_key = probe_ff;
      end else begin : g_mid
         assign left_lt  = cell_lt[i-1];
         assign left_key = cell_key[i-1];
      end

      if (i == skt_pkg::CAPACITY - 1) begin : g_last
         assign right_key = cell_key[i];
      end else begin : g_inner
         assign right_key = cell_key[i+1];
      end

      skt_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .probe_key (probe_ff),
         .occupied  (occ[i]),
         .left_lt   (left_lt),
         .left_key  (left_key),
         .right_key (right_key),
         .key_out   (cell_key[i]),
         .lt_out    (cell_lt[i]),
         .eq_out    (cell_eq[i])
      );

      // The boundary is the first cell whose key is not below the probe.
      assign bnd_vec[i] = !cell_lt[i] && left_lt;
      assign eq_vec[i]  = cell_eq[i];
   end

   if (skt_pkg::PAD > skt_pkg::CAPACITY) begin : g_pad
      assign bnd_vec[skt_pkg::PAD-1:skt_pkg::CAPACITY] = '0;
      assign eq_vec[skt_pkg::PAD-1:skt_pkg::CAPACITY]  = '0;
   end

   skt_encoder u_encoder (
      .clock (clock),
      .bnd   (bnd_vec),
      .eq    (eq_vec),
      .sel   (sel)
   );

   // Sequencer: accept, compare in every cell, two encoder stages, then apply
   // the shift and load the response once the output register is free.
   always_comb begin
      logic is_insert;
      logic is_delete;
      logic table_full;
      logic do_ins;
      logic do_del;
      logic fire;

      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      probe_in     = probe_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      full_in      = full_ff;
      cnt_out_in   = cnt_out_ff;
      ctrl         = '0;
      req_ready    = 1'b0;

      is_insert  = op_ff == skt_pkg::OP_INSERT;
      is_delete  = op_ff == skt_pkg::OP_DELETE;
      table_full = count_ff == skt_pkg::CNT_BITS'(skt_pkg::CAPACITY);
      do_ins     = is_insert && !sel.hit && !table_full;
      do_del     = is_delete && sel.hit;
      fire       = !rsp_valid_ff || rsp_ready;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         skt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_opcode;
               probe_in = skt_pkg::KEY_BITS'(req_key);
               state_in = skt_pkg::ST_COMPARE;
            end
         end
         skt_pkg::ST_COMPARE: begin
            ctrl.compare = 1'b1;
            state_in     = skt_pkg::ST_REDUCE;
         end
         skt_pkg::ST_REDUCE: begin
            state_in = skt_pkg::ST_SELECT;
         end
         skt_pkg::ST_SELECT: begin
            state_in = skt_pkg::ST_APPLY;
         end
         skt_pkg::ST_APPLY: begin
            if (fire) begin
               ctrl.insert  = do_ins;
               ctrl.remove  = do_del;
               if (do_ins) begin
                  count_in = count_ff + skt_pkg::CNT_BITS'(1);
               end else if (do_del) begin
                  count_in = count_ff - skt_pkg::CNT_BITS'(1);
               end
               found_in     = sel.hit;
               pos_in       = (sel.hit || do_ins) ? skt_pkg::POS_BITS'(sel.index) : '0;
               full_in      = is_insert && !sel.hit && table_full;
               cnt_out_in   = skt_pkg::COUNT_OUT_BITS'(count_in);
               rsp_valid_in = 1'b1;
               state_in     = skt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = skt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skt_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      probe_ff   <= probe_in;
      found_ff   <= found_in;
      pos_ff     <= pos_in;
      full_ff    <= full_in;
      cnt_out_ff <= cnt_out_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_position    = pos_ff;
   assign rsp_full_res    = full_ff;
   assign rsp_entry_count = cnt_out_ff;

endmodule

// ===== rtl/skt_checker.sv =====
// Port-level checks for the sorted key table, bound to the top level.
// Depends on skt_pkg and sorted_key_table_unit.
`timescale 1ns / 1ps

module skt_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_found,
   input logic [skt_pkg::POS_BITS-1:0]       rsp_position,
   input logic                               rsp_full_res,
   input logic [skt_pkg::COUNT_OUT_BITS-1:0] rsp_entry_count
);

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) && $stable(rsp_position)
         && $stable(rsp_full_res) && $stable(rsp_entry_count))
      else $error("stalled response changed");

   // A refused insert never reports the key as present.
   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_full_res |-> !rsp_found)
      else $error("full flag together with found");

   // A refused insert reports a full table.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_full_res |->
         rsp_entry_count == skt_pkg::COUNT_OUT_BITS'(skt_pkg::CAPACITY))
      else $error("full flag with table not full");

   // The block is busy in the cycle after taking a transaction.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind sorted_key_table_unit skt_checker u_checker (.*);

// ===== test/sorted_key_table_checker.sv =====
// Checker for the sorted key table: it watches both channels, keeps its own copy of the table,
// predicts each response and compares it field by field. Depends on skt_pkg only.
`timescale 1ns / 1ps

module sorted_key_table_checker import skt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [OPCODE_BITS-1:0]    req_opcode,
   input  logic [REQ_KEY_BITS-1:0]   req_key,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic                      rsp_found,
   input  logic [POS_BITS-1:0]       rsp_position,
   input  logic                      rsp_full_res,
   input  logic [COUNT_OUT_BITS-1:0] rsp_entry_count,
   output int                        failures,
   output int                        outstanding,
   output int                        checked,
   output int                        hits,
   output int                        refusals
);

   typedef struct packed {
      logic                      found;
      logic [POS_BITS-1:0]       position;
      logic                      full_res;
      logic [COUNT_OUT_BITS-1:0] entry_count;
   } answer_type;

   key_type    table_keys [CAPACITY];
   int         held;
   answer_type answers_due [$];

   // Applies one operation to the shadow table and returns the response it should give.
   function automatic answer_type table_operation(logic [OPCODE_BITS-1:0] op, key_type k);
      answer_type ans;
      int         lo;
      int         hi;
      int         mid;
      int         i;
      logic       hit;
      lo = 0;
      hi = held;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (table_keys[mid] < k) lo = mid + 1;
         else hi = mid;
      end
      hit          = (lo < held) && (table_keys[lo] == k);
      ans.found    = hit;
      ans.position = hit ? POS_BITS'(lo) : '0;
      ans.full_res = 1'b0;
      if (op == OP_INSERT && !hit) begin
         if (held >= CAPACITY) begin
            ans.full_res = 1'b1;
         end else begin
            for (i = held; i > lo; i--) table_keys[i] = table_keys[i-1];
            table_keys[lo] = k;
            held++;
            ans.position = POS_BITS'(lo);
         end
      end else if (op == OP_DELETE && hit) begin
         for (i = lo; i + 1 < held; i++) table_keys[i] = table_keys[i+1];
         held--;
      end
      ans.entry_count = COUNT_OUT_BITS'(held);
      return ans;
   endfunction

   always @(posedge clock) begin : watch
      answer_type due;
      int         errs;
      errs = 0;
      if (reset) begin
         held = 0;
         answers_due.delete();
         failures    <= 0;
         outstanding <= 0;
         checked     <= 0;
         hits        <= 0;
         refusals    <= 0;
      end else begin
         // The response is checked before a request in the same cycle is predicted.
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               $error("response transaction arrived with no request outstanding");
               errs++;
            end else begin
               due = answers_due.pop_front();
               if (rsp_found !== due.found) begin
                  $error("found: expected %0d, got %0d", due.found, rsp_found);
                  errs++;
               end
               if (rsp_position !== due.position) begin
                  $error("position: expected %0d, got %0d", due.position, rsp_position);
                  errs++;
               end
               if (rsp_full_res !== due.full_res) begin
                  $error("full_res: expected %0d, got %0d", due.full_res, rsp_full_res);
                  errs++;
               end
               if (rsp_entry_count !== due.entry_count) begin
                  $error("entry_count: expected %0d, got %0d",
                         due.entry_count, rsp_entry_count);
                  errs++;
               end
               checked <= checked + 1;
               if (due.found) hits <= hits + 1;
               if (due.full_res) refusals <= refusals + 1;
            end
         end
         if (req_valid && req_ready)
            answers_due.push_back(table_operation(req_opcode, key_type'(req_key)));
         failures    <= failures + errs;
         outstanding <= answers_due.size();
      end
   end

endmodule

// ===== test/testbench.sv =====
// Top of the sorted key table testbench: clock, reset, request and response traffic, verdict.
// Depends on skt_pkg, sorted_key_table_unit and sorted_key_table_checker.
`timescale 1ns / 1ps

module testbench;
   import skt_pkg::*;

   // Opcode 3 has no meaning of its own; the block must treat it as a lookup.
   localparam logic [OPCODE_BITS-1:0] OP_SPARE = 2'd3;

   localparam int RANDOM_ITEMS = 650;
   localparam int FILL_END     = 320;
   localparam int DRAIN_END    = 520;
   localparam int MAX_IDLE     = 8;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [OPCODE_BITS-1:0]    req_opcode = OP_LOOKUP;
   logic [REQ_KEY_BITS-1:0]   req_key = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_found;
   logic [POS_BITS-1:0]       rsp_position;
   logic                      rsp_full_res;
   logic [COUNT_OUT_BITS-1:0] rsp_entry_count;

   int failures;
   int outstanding;
   int checked;
   int hits;
   int refusals;
   int issued = 0;

   // When set, neither side idles, so that back-to-back transactions are exercised too.
   bit calm = 1'b0;

   // Keys that have been offered for insertion. They are used to aim lookups and deletes at
   // keys that are likely to be held; a key is taken out again when a delete is aimed at it.
   key_type offered_keys [$];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   sorted_key_table_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .rsp_full_res    (rsp_full_res),
      .rsp_entry_count (rsp_entry_count)
   );

   sorted_key_table_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .rsp_full_res    (rsp_full_res),
      .rsp_entry_count (rsp_entry_count),
      .failures        (failures),
      .outstanding     (outstanding),
      .checked         (checked),
      .hits            (hits),
      .refusals        (refusals)
   );

   // Offers one request transaction and returns at the edge at which it is accepted. Valid is
   // only lowered when a gap is drawn, so it never drops and rises within one time step.
   task automatic send_request(input logic [OPCODE_BITS-1:0] op, input key_type k);
      int gap;
      gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_key    <= k;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      issued++;
   endtask

   // Mostly full-width random keys, with clusters at both ends of the key range so that
   // neighbouring keys and the extremes are inserted next to one another.
   function automatic key_type draw_key();
      case ($urandom_range(0, 9))
         0: return key_type'($urandom_range(0, 1023));
         1: return 32'hFFFF_FFFF - key_type'($urandom_range(0, 1023));
         default: return key_type'($urandom());
      endcase
   endfunction

   function automatic key_type offered_key();
      if (offered_keys.size() == 0) return draw_key();
      return offered_keys[$urandom_range(0, offered_keys.size() - 1)];
   endfunction

   // Takes a key out of the offered list, so that deletes mostly find their key.
   function automatic key_type withdraw_key();
      int      idx;
      key_type k;
      if (offered_keys.size() == 0) return draw_key();
      idx = $urandom_range(0, offered_keys.size() - 1);
      k   = offered_keys[idx];
      offered_keys.delete(idx);
      return k;
   endfunction

   task automatic insert_fresh();
      key_type k;
      k = draw_key();
      offered_keys.push_back(k);
      send_request(OP_INSERT, k);
   endtask

   // The response side draws a stall for every transaction, then holds ready until it lands.
   initial begin : response_side
      int stall;
      @(negedge reset);
      forever begin
         stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin : stimulus
      int n;
      int roll;
      int spin;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening: the empty table, the key extremes, a duplicate insert, deletes at
      // the front, middle and back, misses of every kind and the spare opcode. The table is
      // left empty again at the end.
      send_request(OP_LOOKUP, 32'h0000_0000);
      send_request(OP_DELETE, 32'h0000_0005);
      send_request(OP_INSERT, 32'h8000_0000);
      send_request(OP_INSERT, 32'h0000_0000);
      send_request(OP_INSERT, 32'hFFFF_FFFF);
      send_request(OP_INSERT, 32'h0000_0000);
      send_request(OP_INSERT, 32'h0000_0001);
      send_request(OP_INSERT, 32'hFFFF_FFFE);
      send_request(OP_LOOKUP, 32'hFFFF_FFFF);
      send_request(OP_LOOKUP, 32'h0000_0000);
      send_request(OP_LOOKUP, 32'h0000_0002);
      send_request(OP_SPARE,  32'h0000_0001);
      send_request(OP_SPARE,  32'h0000_0007);
      send_request(OP_DELETE, 32'h8000_0000);
      send_request(OP_DELETE, 32'h0000_0000);
      send_request(OP_DELETE, 32'hFFFF_FFFF);
      send_request(OP_DELETE, 32'h8000_0000);
      send_request(OP_INSERT, 32'h5555_5555);
      send_request(OP_INSERT, 32'hAAAA_AAAA);
      send_request(OP_LOOKUP, 32'hAAAA_AAAA);
      send_request(OP_DELETE, 32'h0000_0001);
      send_request(OP_DELETE, 32'hFFFF_FFFE);
      send_request(OP_DELETE, 32'h5555_5555);
      send_request(OP_DELETE, 32'hAAAA_AAAA);

      // Random part in three stretches. The first fills the table well past its capacity,
      // so that inserts are refused once it is full; the second drains it mainly by deletes
      // of held keys; the third mixes everything around a middling fill level.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 99);
         if (n < FILL_END) begin
            if (roll < 86)      insert_fresh();
            else if (roll < 92) send_request(OP_LOOKUP, offered_key());
            else if (roll < 96) send_request(OP_INSERT, offered_key());
            else if (roll < 98) send_request(OP_DELETE, draw_key());
            else                send_request(OP_SPARE, offered_key());
         end else if (n < DRAIN_END) begin
            if (roll < 65)      send_request(OP_DELETE, withdraw_key());
            else if (roll < 80) send_request(OP_LOOKUP, offered_key());
            else if (roll < 90) insert_fresh();
            else if (roll < 95) send_request(OP_LOOKUP, draw_key());
            else                send_request(OP_SPARE, draw_key());
         end else begin
            if (roll < 35)      insert_fresh();
            else if (roll < 60) send_request(OP_DELETE, withdraw_key());
            else if (roll < 85) send_request(OP_LOOKUP, offered_key());
            else if (roll < 95) send_request(OP_LOOKUP, draw_key());
            else                send_request(OP_SPARE, offered_key());
         end
      end

      // The last transaction was accepted at this edge; the checker's count of outstanding
      // responses reflects it from the next edge on.
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      // A further wait catches any response that should not have come.
      for (spin = 0; spin < 20; spin++) @(posedge clock);

      $display("Issued %0d request transactions; %0d responses checked.", issued, checked);
      $display("Of those, %0d found their key and %0d inserts were refused on a full table.",
               hits, refusals);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog: a correct run takes a small fraction of this time.
   initial begin : watchdog
      #500_000;
      $display("FAILURE");
      $finish;
   end

endmodule
